// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/sx7fa_pkg.sv =====
// ----------------------------------------------------------------------------
// sx7fa_pkg
// Types and constants shared by the SysEx 7-bit field access block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sx7fa_pkg;

    localparam int STORE_BYTES     = 512;
    localparam int MAX_FIELD_BYTES = 4;
    localparam int FIRST_W         = 9;
    localparam int COUNT_W         = 3;
    localparam int VALUE_W         = 32;
    localparam int ADDR_W          = $clog2(STORE_BYTES);
    // Position register holds a walked position one past the store.
    localparam int POS_W           = ((ADDR_W > FIRST_W) ? ADDR_W : FIRST_W) + 1;

    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_READ = 2'd1,
        MODE_GET  = 2'd2,
        MODE_SET  = 2'd3
    } mode_t;

    // Memory access selection: raw position, data position, overflow byte.
    typedef enum logic [1:0] {
        SEL_RAW  = 2'd0,
        SEL_DATA = 2'd1,
        SEL_OVF  = 2'd2
    } acc_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WALK,
        ST_RAW,
        ST_RAW_WAIT,
        ST_G_DATA,
        ST_G_OVF,
        ST_G_MERGE,
        ST_S_DATA,
        ST_S_RDOVF,
        ST_S_WROVF,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic     load_in;
        logic     set_err;
        logic     walk_init;
        logic     step;
        logic     mem_rd;
        logic     mem_wr;
        acc_sel_t sel;
        logic     cap_raw;
        logic     cap_byte;
        logic     merge;
        logic     finish;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  raw_oob;
        logic  field_bad;
        logic  count_zero;
        logic  walk_oob;
        logic  last;
        logic  out_free;
    } stat_t;

endpackage

// ===== hdl/sysex_7bit_field_access.sv =====
// ----------------------------------------------------------------------------
// sysex_7bit_field_access
// Field access to the data area of a 7-bit SysEx message with overflow bytes.
// ----------------------------------------------------------------------------
// The block keeps a 512-byte message data area in a single-port memory, in
// which every position that is a multiple of eight is an overflow byte holding
// bit 7 of the seven data bytes after it. Each input word is handled on its
// own. Each field byte costs one walk step for the range check and then a
// data read, an overflow read and a merge for a get, or a data write and an
// overflow read-modify-write for a set, with all memory accesses through the
// one memory port. A result waits in an output register, so the next word can
// be accepted while it is still unclaimed, but a word is only finished once
// that register is free. The store has no reset; entries read before they
// were written give undefined data. The message valid flag is written through
// cfg_write_en and cfg_write_data and should only be changed while no word is
// in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sysex_7bit_field_access
    import sx7fa_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write_en,
    input  logic                      cfg_write_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                mode,
    input  logic [FIRST_W-1:0]        first_pos,
    input  logic [COUNT_W-1:0]        byte_count,
    input  logic                      signed_read,
    input  logic signed [VALUE_W-1:0] write_value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [VALUE_W-1:0] read_value,
    output logic                      error
);

    cmd_t  cmd;
    stat_t stat;

    // The controller decides the sequence of steps for each word.
    sx7fa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the word, the store and the output register.
    sx7fa_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .mode           (mode),
        .first_pos      (first_pos),
        .byte_count     (byte_count),
        .signed_read    (signed_read),
        .write_value    (write_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_value     (read_value),
        .error          (error)
    );

endmodule

// ===== hdl/sx7fa_dp.sv =====
// ----------------------------------------------------------------------------
// sx7fa_dp
// Datapath: word registers, message store, position walker and field assembly.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sx7fa_dp
    import sx7fa_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmd_t                      cmd,
    output stat_t                     stat,
    input  logic                      cfg_write_en,
    input  logic                      cfg_write_data,
    input  logic [1:0]                mode,
    input  logic [FIRST_W-1:0]        first_pos,
    input  logic [COUNT_W-1:0]        byte_count,
    input  logic                      signed_read,
    input  logic signed [VALUE_W-1:0] write_value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [VALUE_W-1:0] read_value,
    output logic                      error
);

    logic [7:0]         mem [STORE_BYTES];
    logic [7:0]         mem_q;

    logic               msg_valid_reg;
    logic               out_valid_reg;
    mode_t              mode_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               sgn_reg;
    logic [VALUE_W-1:0] wval_reg;
    logic [FIRST_W-1:0] first_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [COUNT_W-1:0] idx_reg;
    logic [7:0]         data_byte_reg;
    logic [VALUE_W-1:0] result_reg;
    logic               err_reg;
    logic [VALUE_W-1:0] read_value_reg;
    logic               error_reg;

    logic [POS_W-1:0]   cur;
    logic [2:0]         bit_sel;
    logic [ADDR_W-1:0]  mem_addr;
    logic [7:0]         mem_wdata;
    logic [7:0]         wbyte;
    logic [7:0]         full_byte;
    logic [7:0]         ovf_mod;
    logic [VALUE_W-1:0] ext_result;

    // Skip an overflow position if the walker stands on one.
    assign cur     = (pos_reg[2:0] == 3'b000) ? POS_W'(pos_reg + POS_W'(1)) : pos_reg;
    assign bit_sel = 3'(cur[2:0] - 3'd1);
    assign wbyte   = wval_reg[{idx_reg[1:0], 3'b000} +: 8];

    always_comb
    begin
        full_byte          = data_byte_reg;
        full_byte[7]       = data_byte_reg[7] | mem_q[bit_sel];
        ovf_mod            = mem_q;
        ovf_mod[bit_sel]   = wbyte[7];
    end

    always_comb
    begin
        case (cmd.sel)
            SEL_RAW:
            begin
                mem_addr  = pos_reg[ADDR_W-1:0];
                mem_wdata = wval_reg[7:0];
            end
            SEL_DATA:
            begin
                mem_addr  = cur[ADDR_W-1:0];
                mem_wdata = {1'b0, wbyte[6:0]};
            end
            SEL_OVF:
            begin
                mem_addr  = {cur[ADDR_W-1:3], 3'b000};
                mem_wdata = ovf_mod;
            end
            default:
            begin
                mem_addr  = pos_reg[ADDR_W-1:0];
                mem_wdata = wval_reg[7:0];
            end
        endcase
    end

    // Sign extension of a short gathered field from its top byte.
    always_comb
    begin
        ext_result = result_reg;
        if (sgn_reg && (mode_reg == MODE_GET))
        begin
            case (count_reg)
                3'd1:    if (result_reg[7])  ext_result[31:8]  = '1;
                3'd2:    if (result_reg[15]) ext_result[31:16] = '1;
                3'd3:    if (result_reg[23]) ext_result[31:24] = '1;
                default: ext_result = result_reg;
            endcase
        end
    end

    always_comb
    begin
        stat.mode       = mode_reg;
        stat.raw_oob    = (pos_reg >= POS_W'(STORE_BYTES));
        stat.field_bad  = !msg_valid_reg || (count_reg > COUNT_W'(MAX_FIELD_BYTES));
        stat.count_zero = (count_reg == '0);
        stat.walk_oob   = (cur >= POS_W'(STORE_BYTES));
        stat.last       = (COUNT_W'(idx_reg + COUNT_W'(1)) == count_reg);
        stat.out_free   = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        else if (cmd.mem_rd)
        begin
            mem_q <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                msg_valid_reg <= cfg_write_data;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            mode_reg   <= mode_t'(mode);
            count_reg  <= byte_count;
            sgn_reg    <= signed_read;
            wval_reg   <= write_value;
            first_reg  <= first_pos;
            pos_reg    <= POS_W'(first_pos);
            idx_reg    <= '0;
            result_reg <= '0;
            err_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.set_err)
            begin
                err_reg <= 1'b1;
            end
            if (cmd.walk_init)
            begin
                // Rewind to the first position for the memory pass.
                pos_reg <= POS_W'(first_reg);
                idx_reg <= '0;
            end
            else if (cmd.step)
            begin
                pos_reg <= POS_W'(cur + POS_W'(1));
                idx_reg <= COUNT_W'(idx_reg + COUNT_W'(1));
            end
            if (cmd.cap_raw)
            begin
                result_reg <= VALUE_W'(mem_q);
            end
            if (cmd.merge)
            begin
                result_reg <= result_reg
                            | (VALUE_W'(full_byte) << {idx_reg[1:0], 3'b000});
            end
        end
        if (cmd.cap_byte)
        begin
            data_byte_reg <= mem_q;
        end
        if (cmd.finish)
        begin
            read_value_reg <= err_reg ? '0 : ext_result;
            error_reg      <= err_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign error      = error_reg;

    `ASSERT_IMPLIES(a_field_pos, (cmd.mem_rd || cmd.mem_wr) && (cmd.sel != SEL_RAW), (cur[2:0] != 3'b000) && (cur < POS_W'(STORE_BYTES)), "field access at overflow or outside store")
    `ASSERT_IMPLIES(a_idx_range, cmd.step, idx_reg < count_reg, "byte index beyond field")
    `ASSERT_NEXT(a_finish_out, cmd.finish, out_valid_reg, "finished word not presented")
    `ASSERT_IMPLIES(a_err_zero, out_valid_reg && error_reg, read_value_reg == '0, "refused word carries a value")

endmodule

// ===== hdl/sx7fa_ctrl.sv =====
// ----------------------------------------------------------------------------
// sx7fa_ctrl
// Controller: sequences the check, walk and memory steps of one word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sx7fa_ctrl
    import sx7fa_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   raw_mode;

    assign raw_mode = stat.mode inside {MODE_LOAD, MODE_READ};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (in_valid) state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (raw_mode)
                begin
                    state_next = stat.raw_oob ? ST_DONE : ST_RAW;
                end
                else if (stat.field_bad || stat.count_zero)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (stat.walk_oob)
                begin
                    state_next = ST_DONE;
                end
                else if (stat.last)
                begin
                    state_next = (stat.mode == MODE_GET) ? ST_G_DATA : ST_S_DATA;
                end
            end
            ST_RAW:      state_next = (stat.mode == MODE_READ) ? ST_RAW_WAIT : ST_DONE;
            ST_RAW_WAIT: state_next = ST_DONE;
            ST_G_DATA:   state_next = ST_G_OVF;
            ST_G_OVF:    state_next = ST_G_MERGE;
            ST_G_MERGE:  state_next = stat.last ? ST_DONE : ST_G_DATA;
            ST_S_DATA:   state_next = ST_S_RDOVF;
            ST_S_RDOVF:  state_next = ST_S_WROVF;
            ST_S_WROVF:  state_next = stat.last ? ST_DONE : ST_S_DATA;
            ST_DONE:     if (stat.out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.sel  = SEL_RAW;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            ST_CHECK:    cmd.set_err = raw_mode ? stat.raw_oob : stat.field_bad;
            ST_WALK:
            begin
                if (stat.walk_oob)
                begin
                    cmd.set_err = 1'b1;
                end
                else if (stat.last)
                begin
                    cmd.walk_init = 1'b1;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_RAW:
            begin
                cmd.sel = SEL_RAW;
                if (stat.mode == MODE_READ)
                begin
                    cmd.mem_rd = 1'b1;
                end
                else
                begin
                    cmd.mem_wr = 1'b1;
                end
            end
            ST_RAW_WAIT: cmd.cap_raw = 1'b1;
            ST_G_DATA:
            begin
                cmd.sel    = SEL_DATA;
                cmd.mem_rd = 1'b1;
            end
            ST_G_OVF:
            begin
                cmd.sel      = SEL_OVF;
                cmd.mem_rd   = 1'b1;
                cmd.cap_byte = 1'b1;
            end
            ST_G_MERGE:
            begin
                cmd.merge = 1'b1;
                cmd.step  = 1'b1;
            end
            ST_S_DATA:
            begin
                cmd.sel    = SEL_DATA;
                cmd.mem_wr = 1'b1;
            end
            ST_S_RDOVF:
            begin
                cmd.sel    = SEL_OVF;
                cmd.mem_rd = 1'b1;
            end
            ST_S_WROVF:
            begin
                cmd.sel    = SEL_OVF;
                cmd.mem_wr = 1'b1;
                cmd.step   = 1'b1;
            end
            ST_DONE:     cmd.finish = stat.out_free;
            default:     cmd = '0;
        endcase
    end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the SysEx 7-bit field access block.
// ----------------------------------------------------------------------------
// A shadow copy of the message store and of the message valid flag is kept in a
// small scoreboard class. Every word accepted on the input channel is run
// through that copy to work out the result it must produce. Every result
// accepted on the output channel is compared, field by field, with the oldest
// outstanding prediction. A short directed sequence covers raw access, the
// overflow byte handling, sign extension, empty fields, oversized counts,
// fields running off the end of the store and the invalid-message case. It is
// followed by random phases that toggle the message valid flag. Both channels
// idle in random bursts, except in the final stretch of the run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import sx7fa_pkg::*;

    // Cycles without any handshake after which the run is declared hung.
    localparam int HANG_LIMIT = 5000;
    // Quiet cycles allowed after the last result, well beyond the block latency.
    localparam int DRAIN_CYCLES = 30;
    // Extra quiet cycles before the valid flag is rewritten.
    localparam int SETTLE_CYCLES = 8;

    // One predicted or observed result word.
    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      err;
    } field_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow store, prediction and result checking.
    // ------------------------------------------------------------------------
    class field_tracker;
        bit [7:0]      store_copy [STORE_BYTES];
        bit            written    [STORE_BYTES];
        bit            msg_valid;
        int unsigned   walk_pos   [MAX_FIELD_BYTES];
        field_result_t pending_results [$];
        int            failures;
        int            words_seen;
        int            results_checked;
        int            gets_done;
        int            sets_done;
        int            refusals;

        // Walks the data positions of a field, stepping over overflow bytes.
        // Returns 0 if any of them lies outside the store.
        function bit walk_field(int unsigned first, int unsigned count);
            int unsigned p;
            p = first;
            for (int i = 0; i < count; i++)
            begin
                if ((p % 8) == 0)
                    p++;
                if (p >= STORE_BYTES)
                    return 1'b0;
                walk_pos[i] = p;
                p++;
            end
            return 1'b1;
        endfunction

        function bit field_allowed(int unsigned first, int unsigned count);
            if (!msg_valid || count > MAX_FIELD_BYTES)
                return 1'b0;
            return walk_field(first, count);
        endfunction

        // Returns a store entry that this word would read before it has ever
        // been written, or -1 if there is none. Refused words read nothing.
        function int first_unwritten(mode_t m, int unsigned first, int unsigned count);
            int unsigned p;
            int unsigned ovf;
            if (m == MODE_LOAD)
                return -1;
            if (m == MODE_READ)
            begin
                if (first < STORE_BYTES && !written[first])
                    return first;
                return -1;
            end
            if (!field_allowed(first, count))
                return -1;
            for (int i = 0; i < count; i++)
            begin
                p   = walk_pos[i];
                ovf = p & ~32'd7;
                if (m == MODE_GET && !written[p])
                    return p;
                if (!written[ovf])
                    return ovf;
            end
            return -1;
        endfunction

        // Predicts the result of an accepted word and updates the shadow store.
        function void note_word(mode_t m, int unsigned first, int unsigned count,
                                bit sgn, logic [VALUE_W-1:0] wval);
            field_result_t exp_res;
            logic [VALUE_W-1:0] acc;
            logic [VALUE_W-1:0] mask;
            logic [7:0] b;
            int unsigned p;
            int unsigned ovf;
            int unsigned bitpos;
            acc = '0;
            exp_res.err = 1'b0;
            words_seen++;
            if (m == MODE_LOAD || m == MODE_READ)
            begin
                if (first >= STORE_BYTES)
                    exp_res.err = 1'b1;
                else if (m == MODE_LOAD)
                begin
                    store_copy[first] = wval[7:0];
                    written[first]    = 1'b1;
                end
                else
                    acc = {24'd0, store_copy[first]};
            end
            else if (!field_allowed(first, count))
                exp_res.err = 1'b1;
            else if (m == MODE_GET)
            begin
                gets_done++;
                for (int i = 0; i < count; i++)
                begin
                    p      = walk_pos[i];
                    ovf    = p & ~32'd7;
                    bitpos = (p % 8) - 1;
                    b      = store_copy[p];
                    if (store_copy[ovf][bitpos])
                        b[7] = 1'b1;
                    acc[8*i +: 8] = b;
                end
                if (sgn && count > 0 && count < MAX_FIELD_BYTES && acc[count*8-1])
                begin
                    mask = (32'd1 << (count * 8)) - 32'd1;
                    acc  = acc | ~mask;
                end
            end
            else
            begin
                sets_done++;
                for (int i = 0; i < count; i++)
                begin
                    p      = walk_pos[i];
                    ovf    = p & ~32'd7;
                    bitpos = (p % 8) - 1;
                    b      = wval[8*i +: 8];
                    store_copy[p]           = {1'b0, b[6:0]};
                    store_copy[ovf][bitpos] = b[7];
                    written[p]              = 1'b1;
                end
            end
            if (exp_res.err)
                refusals++;
            exp_res.value = acc;
            pending_results.push_back(exp_res);
        endfunction

        function void check_word(logic signed [VALUE_W-1:0] value, logic err);
            field_result_t exp_res;
            if (pending_results.size() == 0)
            begin
                $error("Result word with nothing outstanding: read_value %h, error %b",
                       value, err);
                failures++;
                return;
            end
            exp_res = pending_results.pop_front();
            results_checked++;
            if (value !== exp_res.value)
            begin
                $error("read_value: expected %h, actual %h", exp_res.value, value);
                failures++;
            end
            if (err !== exp_res.err)
            begin
                $error("error: expected %b, actual %b", exp_res.err, err);
                failures++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block connections.
    // ------------------------------------------------------------------------
    logic                      clk            = 1'b0;
    logic                      rst_n          = 1'b0;
    logic                      cfg_write_en   = 1'b0;
    logic                      cfg_write_data = 1'b0;
    logic                      in_valid       = 1'b0;
    logic                      in_ready;
    logic [1:0]                mode           = MODE_LOAD;
    logic [FIRST_W-1:0]        first_pos      = '0;
    logic [COUNT_W-1:0]        byte_count     = '0;
    logic                      signed_read    = 1'b0;
    logic signed [VALUE_W-1:0] write_value    = '0;
    logic                      out_valid;
    logic                      out_ready      = 1'b0;
    logic signed [VALUE_W-1:0] read_value;
    logic                      error;

    field_tracker tracker;

    // When clear, both sides run flat out with no idling.
    bit tx_idling = 1'b1;
    bit rx_idling = 1'b1;
    int hang_count = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    sysex_7bit_field_access u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .first_pos      (first_pos),
        .byte_count     (byte_count),
        .signed_read    (signed_read),
        .write_value    (write_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_value     (read_value),
        .error          (error)
    );

    // ------------------------------------------------------------------------
    // Result side: out_ready is dropped at random while idling is enabled, and
    // every accepted result word is checked at the rising edge.
    // ------------------------------------------------------------------------
    initial
    begin
        int hold;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else if (rx_idling && $urandom_range(0, 6) == 0)
            begin
                hold = $urandom_range(1, 12) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_word(read_value, error);
    end

    // The watchdog restarts on any handshake, on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            hang_count <= 0;
        else
            hang_count <= hang_count + 1;
        if (hang_count >= HANG_LIMIT)
        begin
            $display("Hang: %0d cycles with no handshake", hang_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Input side tasks.
    // ------------------------------------------------------------------------

    // Presents one word at the falling edge and holds it until it is taken.
    // The prediction is made at the very edge at which it is accepted.
    task automatic send_word(mode_t m, int unsigned pos, int unsigned cnt, bit sgn,
                             logic [VALUE_W-1:0] wval);
        @(negedge clk);
        in_valid    <= 1'b1;
        mode        <= m;
        first_pos   <= pos[FIRST_W-1:0];
        byte_count  <= cnt[COUNT_W-1:0];
        signed_read <= sgn;
        write_value <= wval;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.note_word(m, pos, cnt, sgn, wval);
    endtask

    task automatic idle_gap(int cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (cycles - 1)
            @(negedge clk);
    endtask

    // Holds the input side back until every outstanding result has arrived.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
    endtask

    // The valid flag is only rewritten once the block has gone quiet.
    task automatic write_msg_valid(bit v);
        drain_results();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
        tracker.msg_valid = v;
    endtask

    // One random word. Positions lean towards the two ends of the store so
    // that fields running off the end come up often; counts are mostly legal.
    // A word that would read a never-written entry is turned into a raw load
    // of that entry, which fills the store as the run goes on.
    task automatic send_random_word();
        mode_t m;
        int unsigned pos;
        int unsigned cnt;
        int sel;
        int hole;
        sel = $urandom_range(0, 99);
        if (sel < 25)
            m = MODE_LOAD;
        else if (sel < 40)
            m = MODE_READ;
        else if (sel < 70)
            m = MODE_GET;
        else
            m = MODE_SET;
        sel = $urandom_range(0, 99);
        if (sel < 15)
            pos = $urandom_range(STORE_BYTES - 16, STORE_BYTES - 1);
        else if (sel < 25)
            pos = $urandom_range(0, 15);
        else
            pos = $urandom_range(0, STORE_BYTES - 1);
        sel = $urandom_range(0, 15);
        if (sel < 2)
            cnt = 0;
        else if (sel < 13)
            cnt = $urandom_range(1, MAX_FIELD_BYTES);
        else
            cnt = $urandom_range(MAX_FIELD_BYTES + 1, 7);
        hole = tracker.first_unwritten(m, pos, cnt);
        if (hole >= 0)
        begin
            m   = MODE_LOAD;
            pos = hole;
        end
        send_word(m, pos, cnt, $urandom_range(0, 1), $urandom);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial
    begin
        bit [7:0] group_bytes [10];
        int phase_len   [5];
        bit phase_valid [5];
        // First overflow group and the start of the next one. Byte 0 gives top
        // bits to positions 1, 3 and 6; byte 8 gives one to position 9.
        group_bytes = '{8'hA5, 8'h7F, 8'h00, 8'hFF, 8'h01,
                        8'h33, 8'h4C, 8'h12, 8'h01, 8'h7F};
        phase_len   = '{300, 100, 300, 100, 300};
        phase_valid = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        tracker = new();

        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. The message is still invalid after reset, so raw
        // loads work but field access must be refused.
        for (int i = 0; i < 10; i++)
            send_word(MODE_LOAD, i, 0, 1'b0, 32'hFFFF_FF00 | group_bytes[i]);
        send_word(MODE_GET, 1, 2, 1'b0, 32'h0);
        send_word(MODE_SET, 1, 2, 1'b0, 32'h0000_FFFF);

        write_msg_valid(1'b1);
        send_word(MODE_GET, 1, 4, 1'b1, 32'h0);          // top bits restored
        send_word(MODE_GET, 3, 0, 1'b1, 32'h0);          // empty field
        send_word(MODE_GET, 1, 7, 1'b0, 32'h0);          // count too large
        send_word(MODE_SET, 1, 5, 1'b0, 32'h1234_5678);  // count too large
        send_word(MODE_SET, 1, 3, 1'b0, 32'h7F80_FF80);  // top bits into byte 0
        send_word(MODE_GET, 1, 3, 1'b1, 32'h0);          // sign-extended
        send_word(MODE_GET, 1, 4, 1'b1, 32'h0);          // full width, no extension
        send_word(MODE_SET, 2, 0, 1'b0, 32'hFFFF_FFFF);  // empty set writes nothing
        send_word(MODE_READ, 0, 0, 1'b0, 32'h0);         // overflow byte after set
        send_word(MODE_GET, 8, 1, 1'b1, 32'h0);          // starts on an overflow byte
        send_word(MODE_LOAD, STORE_BYTES - 1, 0, 1'b0, 32'h0000_005A);
        send_word(MODE_READ, STORE_BYTES - 1, 7, 1'b1, 32'hFFFF_FFFF);
        send_word(MODE_GET, STORE_BYTES - 3, 4, 1'b0, 32'h0);  // runs off the end
        send_word(MODE_LOAD, STORE_BYTES - 8, 0, 1'b0, 32'h0000_0000);
        send_word(MODE_SET, STORE_BYTES - 7, 4, 1'b0, 32'h8000_0080);
        send_word(MODE_GET, STORE_BYTES - 7, 4, 1'b0, 32'h0);

        // Random phases, alternating the valid flag. Idling is switched off in
        // chunks, and entirely for the tail of the last phase.
        for (int ph = 0; ph < 5; ph++)
        begin
            write_msg_valid(phase_valid[ph]);
            for (int n = 0; n < phase_len[ph]; n++)
            begin
                if (n % 50 == 0)
                begin
                    tx_idling = ($urandom_range(0, 3) != 0);
                    rx_idling = ($urandom_range(0, 3) != 0);
                end
                if (ph == 4 && n >= phase_len[ph] - 150)
                begin
                    tx_idling = 1'b0;
                    rx_idling = 1'b0;
                end
                // Once, midway through the third phase, the sender waits for the block to empty fully.
                if (ph == 2 && n == 150)
                    drain_results();
                if (tx_idling && $urandom_range(0, 5) == 0)
                    idle_gap($urandom_range(1, 12));
                send_random_word();
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Covered %0d words and %0d checked results: %0d field gets, %0d field sets,",
                 tracker.words_seen, tracker.results_checked, tracker.gets_done,
                 tracker.sets_done);
        $display("and %0d refused requests, with the message valid flag both set and clear.",
                 tracker.refusals);
        if (tracker.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
